// File: rtl/cfn_pkg.sv
`default_nettype none

package cfn_pkg;

  localparam int MAX_FRAME  = 256;
  localparam int MIRROR_MAX = 128;

  // Field widths of one item
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 9;
  localparam int MIRROR_W = 8;
  localparam int ADDR_W   = 8;
  localparam int MAC_W    = 12;

  localparam logic [ADDR_W-1:0] ADDR_MAX_ID = 8'd254;
  localparam logic [ADDR_W-1:0] ADDR_SAT    = 8'd255;

  localparam logic [BYTE_W-1:0] CH_M    = 8'h6D;  // 'm'
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] CH_H    = 8'h68;  // 'h'
  localparam logic [BYTE_W-1:0] CH_V    = 8'h76;  // 'v'
  localparam logic [BYTE_W-1:0] CH_A    = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_ADDR   = 6'b000010,
    PH_DIGITS = 6'b000100,
    PH_WILD   = 6'b001000,
    PH_CMD    = 6'b010000,
    PH_PASS   = 6'b100000
  } cfn_phase_e;

endpackage

`default_nettype wire

// File: rtl/command_frame_normalizer.sv
// A frame's verdict becomes valid after its last byte is accepted: the byte sits in the
//   input register, then the verdict is loaded into the result register.
// Throughput: one byte per cycle while the receiver keeps up; a verdict left waiting
//   holds the next byte in the input register and stalls the input.
// Reset (rst_ni low, asynchronous): frame parse state returns to expect-prefix,
//   quiet mode clears, both the input and result registers empty.
`default_nettype none

module command_frame_normalizer import cfn_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,        // quiet_mode
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,     // [7:0] frame_byte
  input  wire logic [0:0]  s_axis_tuser_i,     // [0] raw_mode
  input  wire logic        s_axis_tlast_i,     // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,     // [8:0] send_length, [16:9] mirror_length
  output logic [2:0]       m_axis_tuser_o      // [0] add_newline, [1] suppressed, [2] dropped
);

  // Quiet mode register
  logic quiet_q;

  // Input register
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_raw_q;
  logic              in_last_q;

  // Frame state: current, updated by this byte, and next (cleared after the last byte)
  cfn_phase_e        ph_q, ph_n, ph_d;
  logic [LEN_W-1:0]  cnt_q, cnt_n, cnt_d;
  logic [LEN_W-1:0]  ce_q, ce_n, ce_d;
  logic [LEN_W-1:0]  cp_q, cp_n, cp_d;
  logic [LEN_W-1:0]  dre_q, dre_n, dre_d;
  logic [ADDR_W-1:0] addr_q, addr_n, addr_d;
  logic [BYTE_W-1:0] code_q, code_n, code_d;
  logic [BYTE_W-1:0] bac_q, bac_n, bac_d;
  logic              wild_q, wild_n, wild_d;
  logic              raw_q, raw_n, raw_d;

  // Result register
  logic                out_vld_q, out_vld_d;
  logic [LEN_W-1:0]    send_len_q, send_len_d;
  logic [MIRROR_W-1:0] mirror_len_q, mirror_len_d;
  logic                nl_q, nl_d;
  logic                sup_q, sup_d;
  logic                drop_q, drop_d;

  logic              adv;
  logic              is_dig;
  logic              is_term;
  logic [3:0]        dig_val;
  logic [MAC_W-1:0]  addr_mac;

  logic              addr_ok;
  logic              cmd_in_ce;
  logic [LEN_W-1:0]  cp_p1;
  logic [LEN_W-1:0]  cp_p2;
  logic [LEN_W-1:0]  known_len;
  logic              cmd_in_bare;
  logic              bare_query;
  logic              motion;
  logic [LEN_W-1:0]  bare;
  logic [LEN_W-1:0]  ring_cap;

  // Advance the input register into the frame state when the result side has room.
  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  assign is_dig  = (in_byte_q >= CH_0) && (in_byte_q <= CH_9);
  assign is_term = (in_byte_q == CH_LF) || (in_byte_q == CH_CR);
  assign dig_val = 4'(in_byte_q - CH_0);
  // address * 10 + digit, as two shifts and adds
  assign addr_mac = ({4'd0, addr_q} << 3) + ({4'd0, addr_q} << 1) + {8'd0, dig_val};

  // Parse one byte into the frame state.
  always_comb begin
    ph_n   = ph_q;
    cnt_n  = cnt_q;
    ce_n   = ce_q;
    cp_n   = cp_q;
    dre_n  = dre_q;
    addr_n = addr_q;
    code_n = code_q;
    bac_n  = bac_q;
    wild_n = wild_q;
    raw_n  = raw_q;
    if (adv) begin
      if (cnt_q == '0) begin
        raw_n = in_raw_q;
      end
      // Bytes past the frame limit are only counted.
      if (cnt_q < LEN_W'(MAX_FRAME)) begin
        if (!is_term) begin
          ce_n = cnt_q + LEN_W'(1);
        end
        case (ph_q)
          PH_PREFIX: begin
            ph_n = (in_byte_q == CH_M) ? PH_ADDR : PH_PASS;
          end
          PH_ADDR: begin
            if (in_byte_q == CH_STAR) begin
              wild_n = 1'b1;
              ph_n   = PH_WILD;
            end else if (is_dig) begin
              addr_n = {4'd0, dig_val};
              ph_n   = PH_DIGITS;
            end else begin
              ph_n = PH_PASS;
            end
          end
          PH_DIGITS: begin
            if (is_dig) begin
              addr_n = (addr_mac > MAC_W'(ADDR_SAT)) ? ADDR_SAT : addr_mac[ADDR_W-1:0];
            end else begin
              code_n = in_byte_q;
              cp_n   = cnt_q;
              dre_n  = cnt_q + LEN_W'(1);
              ph_n   = PH_CMD;
            end
          end
          PH_WILD: begin
            code_n = in_byte_q;
            cp_n   = cnt_q;
            dre_n  = cnt_q + LEN_W'(1);
            ph_n   = PH_CMD;
          end
          PH_CMD: begin
            if (cnt_q == cp_q + LEN_W'(1)) begin
              bac_n = in_byte_q;
            end
            // Extend the digit run that directly follows the command.
            if ((dre_q == cnt_q) && is_dig) begin
              dre_n = cnt_q + LEN_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cnt_q <= LEN_W'(MAX_FRAME)) begin
        cnt_n = cnt_q + LEN_W'(1);
      end
    end
  end

  // Verdict, taken from the state after this byte.
  assign addr_ok   = wild_n || (addr_n <= ADDR_MAX_ID);
  assign cmd_in_ce = (ph_n == PH_CMD) && (cp_n < ce_n) && addr_ok;
  assign cp_p1     = cp_n + LEN_W'(1);
  assign cp_p2     = cp_n + LEN_W'(2);

  // Trim junk after a complete command.
  always_comb begin
    known_len = ce_n;
    if (cmd_in_ce) begin
      case (code_n)
        CH_H:     known_len = cp_p1;
        CH_V,
        CH_A:     known_len = wild_n ? ce_n : cp_p1;
        CH_MINUS: known_len = (cp_p1 < ce_n) ? cp_p2 : cp_p1;
        CH_PLUS: begin
          if (dre_n == cp_p1) begin
            known_len = ce_n;
          end else begin
            known_len = (dre_n < ce_n) ? dre_n : ce_n;
          end
        end
        default:  known_len = ce_n;
      endcase
    end
  end

  always_comb begin
    drop_d = 1'b0;
    bare   = '0;
    if (cnt_n > LEN_W'(MAX_FRAME)) begin
      drop_d = 1'b1;
    end else if (raw_n) begin
      bare = cnt_n;
    end else if (ce_n == '0) begin
      drop_d = 1'b1;
    end else begin
      bare = known_len;
    end
  end

  assign cmd_in_bare = (ph_n == PH_CMD) && (cp_n < bare) && addr_ok;
  // A bare numeric-id version query goes out without a terminator.
  assign bare_query  = cmd_in_bare && (code_n == CH_V) && !wild_n && (cp_p1 == bare);
  assign motion = cmd_in_bare &&
                  ((code_n == CH_MINUS) || (code_n == CH_PLUS) ||
                   ((code_n == CH_H) &&
                    ((cp_p1 >= bare) || (bac_n == CH_LF) || (bac_n == CH_CR))));

  assign ring_cap = (bare > LEN_W'(MIRROR_MAX)) ? LEN_W'(MIRROR_MAX) : bare;

  always_comb begin
    sup_d        = !drop_d && quiet_q && motion;
    send_len_d   = '0;
    nl_d         = 1'b0;
    mirror_len_d = '0;
    if (!drop_d && !sup_d) begin
      send_len_d   = bare;
      nl_d         = !raw_n && !bare_query;
      mirror_len_d = MIRROR_W'(ring_cap);
      if (nl_d && (ring_cap < LEN_W'(MIRROR_MAX))) begin
        mirror_len_d = MIRROR_W'(ring_cap + LEN_W'(1));
      end
    end
  end

  // Clear the frame state after the last byte.
  always_comb begin
    if (adv && in_last_q) begin
      ph_d   = PH_PREFIX;
      cnt_d  = '0;
      ce_d   = '0;
      cp_d   = '0;
      dre_d  = '0;
      addr_d = '0;
      code_d = '0;
      bac_d  = '0;
      wild_d = 1'b0;
      raw_d  = 1'b0;
    end else begin
      ph_d   = ph_n;
      cnt_d  = cnt_n;
      ce_d   = ce_n;
      cp_d   = cp_n;
      dre_d  = dre_n;
      addr_d = addr_n;
      code_d = code_n;
      bac_d  = bac_n;
      wild_d = wild_n;
      raw_d  = raw_n;
    end
  end

  // Load a verdict on the last byte; drop it once taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q   <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ph_q      <= PH_PREFIX;
      cnt_q     <= '0;
      ce_q      <= '0;
      cp_q      <= '0;
      dre_q     <= '0;
      addr_q    <= '0;
      code_q    <= '0;
      bac_q     <= '0;
      wild_q    <= 1'b0;
      raw_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quiet_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      out_vld_q <= out_vld_d;
      ph_q      <= ph_d;
      cnt_q     <= cnt_d;
      ce_q      <= ce_d;
      cp_q      <= cp_d;
      dre_q     <= dre_d;
      addr_q    <= addr_d;
      code_q    <= code_d;
      bac_q     <= bac_d;
      wild_q    <= wild_d;
      raw_q     <= raw_d;
    end
  end

  // Payload registers: hold the input item until it advances, the verdict until taken.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_raw_q  <= s_axis_tuser_i[0];
      in_last_q <= s_axis_tlast_i;
    end
    if (adv && in_last_q) begin
      send_len_q   <= send_len_d;
      mirror_len_q <= mirror_len_d;
      nl_q         <= nl_d;
      sup_q        <= sup_d;
      drop_q       <= drop_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, mirror_len_q, send_len_q};
  assign m_axis_tuser_o  = {drop_q, sup_q, nl_q};

endmodule

`default_nettype wire
